### hdl/crc8fras_pkg.sv
// ----------------------------------------------------------------------------
// crc8fras_pkg
// shared constants and the crc-8 byte fold for the framed register slave
// ----------------------------------------------------------------------------
package crc8fras_pkg;

  localparam int MAX_PAYLOAD_DEF = 32;
  localparam int REG_COUNT_DEF   = 64;

  localparam logic [7:0] SOF_BYTE      = 8'hAA;
  localparam logic [7:0] CMD_READ      = 8'h01;
  localparam logic [7:0] CMD_WRITE     = 8'h02;
  localparam logic [7:0] CMD_HEARTBEAT = 8'h03;
  localparam logic [7:0] REPLY_FLAG    = 8'h80;
  localparam logic [7:0] STATUS_OK     = 8'h00;
  localparam logic [7:0] STATUS_ERR    = 8'h01;
  localparam logic [7:0] CRC_POLY      = 8'h07;

  // msb-first crc-8, one byte folded into the running value
  function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] x;
    x = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if (x[7]) begin
        x = {x[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        x = {x[6:0], 1'b0};
      end
    end
    return x;
  endfunction

endpackage

### hdl/crc8_framed_register_access_slave_unit.sv
// ----------------------------------------------------------------------------
// crc8_framed_register_access_slave_unit
// parses crc-8 framed register read/write requests and streams framed replies
// ----------------------------------------------------------------------------
// after the closing crc byte transfer, a write first copies its payload into the
//   register file; the reply bytes then pass through the output register
// throughput: one received byte per cycle while parsing; header, status and crc
//   bytes one per cycle unless out_tready stalls; each read data byte waits on a fetch state (registered file read)
// in_tready is low from the closing crc byte until the reply crc byte is loaded
// reset: synchronous, active low; parser idle, register file zero via valid bits
module crc8_framed_register_access_slave_unit #(
  parameter int MAX_PAYLOAD = crc8fras_pkg::MAX_PAYLOAD_DEF,
  parameter int REG_COUNT   = crc8fras_pkg::REG_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  // received byte stream
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] rx_byte
  // reply byte stream
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] tx_byte
  output logic       out_tlast,  // last_byte: reply crc byte
  output logic       out_tuser   // [0] wrote_registers
);
  import crc8fras_pkg::*;

  // index widths for the payload buffer and the register file
  localparam int PW  = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int RAW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam logic [7:0] MAX_B  = 8'(MAX_PAYLOAD);
  localparam logic [5:0] MAX_6  = 6'(MAX_PAYLOAD);
  localparam logic [8:0] RC_9   = 9'(REG_COUNT);

  // frame parser phases
  localparam logic [2:0] PH_WAIT = 3'd0;
  localparam logic [2:0] PH_CMD  = 3'd1;
  localparam logic [2:0] PH_REG  = 3'd2;
  localparam logic [2:0] PH_LEN  = 3'd3;
  localparam logic [2:0] PH_DATA = 3'd4;
  localparam logic [2:0] PH_CRC  = 3'd5;

  // sequencer states
  localparam logic [2:0] ST_RX    = 3'd0;  // taking received bytes
  localparam logic [2:0] ST_COPY  = 3'd1;  // payload into register file
  localparam logic [2:0] ST_HDR   = 3'd2;  // reply header bytes
  localparam logic [2:0] ST_FETCH = 3'd3;  // register file read issue
  localparam logic [2:0] ST_DATA  = 3'd4;  // read data byte out
  localparam logic [2:0] ST_STAT  = 3'd5;  // status byte out
  localparam logic [2:0] ST_CRC   = 3'd6;  // reply crc byte out

  // header byte positions
  localparam logic [1:0] HB_SOF = 2'd0;
  localparam logic [1:0] HB_CMD = 2'd1;
  localparam logic [1:0] HB_REG = 2'd2;
  localparam logic [1:0] HB_LEN = 2'd3;

  logic [2:0] state_r, state_nxt;
  logic [2:0] phase_r, phase_nxt;
  logic [7:0] cmd_r, cmd_nxt;
  logic [7:0] reg_r, reg_nxt;
  logic [5:0] len_r, len_nxt;
  logic [5:0] pos_r, pos_nxt;
  logic [5:0] idx_r, idx_nxt;
  logic [1:0] hdr_r, hdr_nxt;
  logic [7:0] crc_r, crc_nxt;
  logic       err_r, err_nxt;
  logic       isrd_r, isrd_nxt;
  logic       wrote_r, wrote_nxt;

  logic       out_tvalid_r, out_tvalid_nxt;
  logic [7:0] out_tdata_r, out_tdata_nxt;
  logic       out_tlast_r, out_tlast_nxt;
  logic       out_tuser_r, out_tuser_nxt;

  logic [REG_COUNT-1:0] rf_valid_r;
  logic [7:0]           rf_mem [REG_COUNT];
  logic [7:0]           rf_rdata_r;
  logic                 rf_rvalid_r;
  logic [7:0]           pl_mem [MAX_PAYLOAD];

  logic       rx_fire;
  logic       slot_free;
  logic       emit;
  logic [7:0] tx_byte;
  logic       tx_last;
  logic       tx_wrote;
  logic [7:0] fold_data;
  logic [7:0] fold_out;
  logic [8:0] addr_sum;
  logic [RAW-1:0] rf_addr;
  logic       rf_we;
  logic       pl_we;
  logic [5:0] pos_inc;
  logic [5:0] idx_inc;
  logic [8:0] reg_9;
  logic       range_ok;
  logic       hb_cmd;
  logic       rd_ok;
  logic       wr_ok;

  assign in_tready  = (state_r == ST_RX);
  assign rx_fire    = in_tvalid && in_tready;
  assign slot_free  = !out_tvalid_r || out_tready;

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;
  assign out_tuser  = out_tuser_r;

  // shared adder: register base plus running index, for copy and read
  assign addr_sum = {1'b0, reg_r} + {3'b000, idx_r};
  assign rf_addr  = addr_sum[RAW-1:0];

  assign pos_inc = pos_r + 6'd1;
  assign idx_inc = idx_r + 6'd1;

  // request range check, same rule for read and write
  assign reg_9    = {1'b0, reg_r};
  assign range_ok = (len_r != 6'd0) && (reg_9 < RC_9) &&
                    ((reg_9 + {3'b000, len_r}) <= RC_9);
  assign hb_cmd   = (cmd_r == CMD_HEARTBEAT);
  assign rd_ok    = (cmd_r == CMD_READ) && range_ok;
  assign wr_ok    = (cmd_r == CMD_WRITE) && range_ok;

  // reply byte selection
  always_comb begin
    emit     = 1'b0;
    tx_byte  = 8'h00;
    tx_last  = 1'b0;
    tx_wrote = 1'b0;
    case (state_r)
      ST_HDR: begin
        emit = slot_free;
        case (hdr_r)
          HB_SOF:  tx_byte = SOF_BYTE;
          HB_CMD:  tx_byte = cmd_r | REPLY_FLAG;
          HB_REG:  tx_byte = reg_r;
          HB_LEN:  tx_byte = {2'b00, len_r};
          default: tx_byte = SOF_BYTE;
        endcase
      end
      ST_DATA: begin
        emit    = slot_free;
        tx_byte = rf_rvalid_r ? rf_rdata_r : 8'h00;
      end
      ST_STAT: begin
        emit    = slot_free;
        tx_byte = err_r ? STATUS_ERR : STATUS_OK;
      end
      ST_CRC: begin
        emit     = slot_free;
        tx_byte  = crc_r;
        tx_last  = 1'b1;
        tx_wrote = wrote_r;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // the one crc unit: folds received bytes while parsing, reply bytes after
  assign fold_data = (state_r == ST_RX) ? in_tdata : tx_byte;
  assign fold_out  = crc_fold(crc_r, fold_data);

  // sequencer and parser
  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    cmd_nxt   = cmd_r;
    reg_nxt   = reg_r;
    len_nxt   = len_r;
    pos_nxt   = pos_r;
    idx_nxt   = idx_r;
    hdr_nxt   = hdr_r;
    crc_nxt   = crc_r;
    err_nxt   = err_r;
    isrd_nxt  = isrd_r;
    wrote_nxt = wrote_r;
    pl_we     = 1'b0;
    rf_we     = 1'b0;

    case (state_r)
      ST_RX: begin
        if (rx_fire) begin
          case (phase_r)
            PH_WAIT: begin
              if (in_tdata == SOF_BYTE) begin
                crc_nxt   = fold_out;
                phase_nxt = PH_CMD;
              end
            end
            PH_CMD: begin
              cmd_nxt   = in_tdata;
              crc_nxt   = fold_out;
              phase_nxt = PH_REG;
            end
            PH_REG: begin
              reg_nxt   = in_tdata;
              crc_nxt   = fold_out;
              phase_nxt = PH_LEN;
            end
            PH_LEN: begin
              if (in_tdata > MAX_B) begin
                // oversized length drops the frame
                phase_nxt = PH_WAIT;
                cmd_nxt   = 8'h00;
                reg_nxt   = 8'h00;
                len_nxt   = 6'd0;
                pos_nxt   = 6'd0;
                crc_nxt   = 8'h00;
              end else begin
                len_nxt = in_tdata[5:0];
                pos_nxt = 6'd0;
                crc_nxt = fold_out;
                if (in_tdata == 8'h00 || cmd_r inside {CMD_READ, CMD_HEARTBEAT}) begin
                  phase_nxt = PH_CRC;
                end else begin
                  phase_nxt = PH_DATA;
                end
              end
            end
            PH_DATA: begin
              pl_we   = 1'b1;
              pos_nxt = pos_inc;
              crc_nxt = fold_out;
              if (pos_inc >= len_r || pos_inc >= MAX_6) begin
                phase_nxt = PH_CRC;
              end
            end
            PH_CRC: begin
              phase_nxt = PH_WAIT;
              pos_nxt   = 6'd0;
              crc_nxt   = 8'h00;
              if (in_tdata == crc_r) begin
                // set up the reply; the crc register restarts for it
                // a write keeps its length for the copy, which then sets 1
                reg_nxt   = hb_cmd ? 8'h00 : reg_r;
                len_nxt   = (rd_ok || wr_ok) ? len_r : 6'd1;
                err_nxt   = !(hb_cmd || rd_ok || wr_ok);
                isrd_nxt  = rd_ok && !hb_cmd;
                wrote_nxt = wr_ok;
                idx_nxt   = 6'd0;
                hdr_nxt   = HB_SOF;
                state_nxt = wr_ok ? ST_COPY : ST_HDR;
              end else begin
                cmd_nxt = 8'h00;
                reg_nxt = 8'h00;
                len_nxt = 6'd0;
              end
            end
            default: begin
              phase_nxt = PH_WAIT;
              cmd_nxt   = 8'h00;
              reg_nxt   = 8'h00;
              len_nxt   = 6'd0;
              pos_nxt   = 6'd0;
              crc_nxt   = 8'h00;
            end
          endcase
        end
      end
      ST_COPY: begin
        rf_we   = 1'b1;
        idx_nxt = idx_inc;
        if (idx_inc == len_r) begin
          idx_nxt   = 6'd0;
          len_nxt   = 6'd1;
          state_nxt = ST_HDR;
        end
      end
      ST_HDR: begin
        if (emit) begin
          crc_nxt = fold_out;
          hdr_nxt = hdr_r + 2'd1;
          if (hdr_r == HB_LEN) begin
            state_nxt = isrd_r ? ST_FETCH : ST_STAT;
          end
        end
      end
      ST_FETCH: begin
        state_nxt = ST_DATA;
      end
      ST_DATA: begin
        if (emit) begin
          crc_nxt = fold_out;
          idx_nxt = idx_inc;
          state_nxt = (idx_inc == len_r) ? ST_CRC : ST_FETCH;
        end
      end
      ST_STAT: begin
        if (emit) begin
          crc_nxt   = fold_out;
          state_nxt = ST_CRC;
        end
      end
      ST_CRC: begin
        if (emit) begin
          state_nxt = ST_RX;
          cmd_nxt   = 8'h00;
          reg_nxt   = 8'h00;
          len_nxt   = 6'd0;
          idx_nxt   = 6'd0;
          crc_nxt   = 8'h00;
        end
      end
      default: begin
        state_nxt = ST_RX;
        phase_nxt = PH_WAIT;
        crc_nxt   = 8'h00;
      end
    endcase
  end

  // output register, holds a byte until its transfer
  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    out_tlast_nxt  = out_tlast_r;
    out_tuser_nxt  = out_tuser_r;
    if (emit) begin
      out_tvalid_nxt = 1'b1;
      out_tdata_nxt  = tx_byte;
      out_tlast_nxt  = tx_last;
      out_tuser_nxt  = tx_wrote;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_RX;
      phase_r      <= PH_WAIT;
      cmd_r        <= 8'h00;
      reg_r        <= 8'h00;
      len_r        <= 6'd0;
      pos_r        <= 6'd0;
      idx_r        <= 6'd0;
      hdr_r        <= HB_SOF;
      crc_r        <= 8'h00;
      err_r        <= 1'b0;
      isrd_r       <= 1'b0;
      wrote_r      <= 1'b0;
      out_tvalid_r <= 1'b0;
      rf_valid_r   <= '0;
    end else begin
      state_r      <= state_nxt;
      phase_r      <= phase_nxt;
      cmd_r        <= cmd_nxt;
      reg_r        <= reg_nxt;
      len_r        <= len_nxt;
      pos_r        <= pos_nxt;
      idx_r        <= idx_nxt;
      hdr_r        <= hdr_nxt;
      crc_r        <= crc_nxt;
      err_r        <= err_nxt;
      isrd_r       <= isrd_nxt;
      wrote_r      <= wrote_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (rf_we) begin
        rf_valid_r[rf_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_tdata_r <= out_tdata_nxt;
    out_tlast_r <= out_tlast_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  // payload buffer, written while parsing, read during the copy
  always_ff @(posedge clk) begin
    if (pl_we) begin
      pl_mem[pos_r[PW-1:0]] <= in_tdata;
    end
  end

  // register file: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf_mem[rf_addr] <= pl_mem[idx_r[PW-1:0]];
    end
    rf_rdata_r  <= rf_mem[rf_addr];
    rf_rvalid_r <= rf_valid_r[rf_addr];
  end

endmodule

### hdl/crc8fras_checker.sv
// ----------------------------------------------------------------------------
// crc8fras_checker
// port-level checks on the framed register slave, bound to the top level
// ----------------------------------------------------------------------------
module crc8fras_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast,
  input logic       out_tuser
);
  import crc8fras_pkg::*;

  // a stalled reply byte keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("reply byte changed while stalled");

  // no received byte is taken while a reply is still being produced
  a_no_rx_mid_reply: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("input ready in the middle of a reply");

  // the write flag only rides on the closing crc byte
  a_wrote_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("write flag on a byte other than the reply crc");

  // a byte right after a finished reply opens a new reply frame
  a_reply_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && $past(out_tvalid && out_tready && out_tlast) |-> out_tdata == SOF_BYTE)
    else $error("reply frame does not open with the start byte");

endmodule

bind crc8_framed_register_access_slave_unit crc8fras_checker u_crc8fras_checker (.*);
